[hw/rtl/field_oriented_mecanum_mixer_defines.svh]
// ----------------------------------------------------------------------------
// Field-oriented mecanum mixer: shared assertion macros
// Concurrent assertion wrappers used by the checker of the mixer.
// ----------------------------------------------------------------------------
`ifndef FIELD_ORIENTED_MECANUM_MIXER_DEFINES_SVH
`define FIELD_ORIENTED_MECANUM_MIXER_DEFINES_SVH

// Assertion that is switched off while reset is held.
`define FOMM_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Assertion that is also checked during reset.
`define FOMM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hw/rtl/fomm_pkg.sv]
// ----------------------------------------------------------------------------
// fomm_pkg
// Types, constants and arithmetic helpers shared by the mecanum mixer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package fomm_pkg;

    // Default angle resolution of the sine lookup (steps per turn = 2**bits).
    localparam int TRIG_TABLE_BITS_DEF = 10;

    // Fixed-point constants.
    localparam int Q14_ONE      = 16384;
    localparam int APB_AW       = 4;
    localparam int W_S          = 18;   // rounded stick products
    localparam int W_TW         = 27;   // twist, wide enough for autonomous twist
    localparam int W_ROT        = 19;   // rotated vector
    localparam int W_WHEEL      = 28;   // raw wheel sums
    localparam int W_MAG        = 27;   // wheel magnitudes
    localparam int W_QUO        = 15;   // equalized magnitude
    localparam int W_REM        = 43;   // divider remainder
    localparam int W_DIV        = 28;   // divider denominator (twice the max)

    // Register indexes.
    localparam logic [1:0] REG_IN_DB     = 2'd0;
    localparam logic [1:0] REG_OUT_DB    = 2'd1;
    localparam logic [1:0] REG_AUTON_FWD = 2'd2;

    // Register reset values.
    localparam logic [14:0]        IN_DB_RST     = 15'd2458;
    localparam logic [14:0]        OUT_DB_RST    = 15'd3277;
    localparam logic signed [15:0] AUTON_FWD_RST = -16'sd4915;

    // Odd polynomial for sin(pi/2 * x), coefficients in Q30.
    localparam logic [63:0] SIN_C1 = 64'd1686629713;
    localparam logic [63:0] SIN_C3 = 64'd693598668;
    localparam logic [63:0] SIN_C5 = 64'd85569305;
    localparam logic [63:0] SIN_C7 = 64'd5026994;
    localparam logic [63:0] SIN_C9 = 64'd172272;
    localparam logic [63:0] Q30_ONE = 64'd1073741824;

    // One command transaction.
    typedef struct packed {
        logic               mode;
        logic signed [15:0] stick_x;
        logic signed [15:0] stick_y;
        logic signed [15:0] stick_twist;
        logic signed [15:0] throttle;
        logic signed [23:0] heading;
    } t_cmd;

    // One result transaction.
    typedef struct packed {
        logic signed [15:0] front_left_speed;
        logic signed [15:0] front_right_speed;
        logic signed [15:0] back_left_speed;
        logic signed [15:0] back_right_speed;
    } t_speeds;

    // Data handed along the divider cells.
    typedef struct packed {
        logic                           flag;
        logic [3:0]                     neg;
        logic [3:0][W_MAG-1:0]          mag;
        logic [3:0][W_REM-1:0]          rem;
        logic [3:0][W_QUO-1:0]          quo;
        logic [W_DIV-1:0]               div;
    } t_div_bus;

    // Quarter-wave sine, x in Q30 over 0..1, result in Q1.14.
    function automatic logic [14:0] quarter_sine(input logic [63:0] x);
        logic [63:0] x2;
        logic [63:0] p;
        x2 = (x * x) >> 30;
        p  = SIN_C7 - ((x2 * SIN_C9) >> 30);
        p  = SIN_C5 - ((x2 * p) >> 30);
        p  = SIN_C3 - ((x2 * p) >> 30);
        p  = SIN_C1 - ((x2 * p) >> 30);
        p  = (x * p) >> 30;
        p  = (p + 64'd32768) >> 16;
        if (p > 64'd16384) begin
            p = 64'd16384;
        end
        return p[14:0];
    endfunction

    // Divide a product by 2**14, rounding to nearest with ties away from zero.
    function automatic logic signed [39:0] mulq_round(input logic signed [39:0] p);
        logic [39:0] mag;
        logic [39:0] q;
        mag = p[39] ? (~p + 40'd1) : p;
        q   = (mag + 40'd8192) >> 14;
        return p[39] ? -$signed(q) : $signed(q);
    endfunction

    // Zero a value whose magnitude is below the threshold.
    function automatic logic signed [39:0] dead_zone(input logic signed [39:0] v,
                                                     input logic [14:0] th);
        logic [39:0] mag;
        mag = v[39] ? (~v + 40'd1) : v;
        return (mag < {25'd0, th}) ? 40'sd0 : v;
    endfunction

    // Saturate to -1.0 .. +1.0 in Q1.14.
    function automatic logic signed [15:0] sat_q14(input logic signed [39:0] v);
        logic signed [15:0] r;
        if (v > 40'sd16384) begin
            r = 16'sd16384;
        end else if (v < -40'sd16384) begin
            r = -16'sd16384;
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

endpackage

[hw/rtl/fomm_front.sv]
// ----------------------------------------------------------------------------
// fomm_front
// Elastic front pipeline: stick scaling, heading trig, rotation, wheel mix
// and the start of the equalizing division.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fomm_front #(
    parameter int TRIG_TABLE_BITS = fomm_pkg::TRIG_TABLE_BITS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  fomm_pkg::t_cmd           i_cmd,
    input  logic                     i_vld,
    output logic                     o_rdy,
    input  logic [14:0]              i_in_db,
    input  logic signed [15:0]       i_auton_fwd,
    output fomm_pkg::t_div_bus       o_bus,
    output logic                     o_vld,
    input  logic                     i_rdy
);

    localparam int NS       = 8;
    localparam int QTR_BITS = TRIG_TABLE_BITS - 2;
    localparam int QTR      = 1 << QTR_BITS;
    localparam int N_W      = 25 + TRIG_TABLE_BITS;
    localparam int M_W      = N_W - 9;
    localparam int FR_SHIFT = 32 - TRIG_TABLE_BITS;
    localparam int W_S      = fomm_pkg::W_S;
    localparam int W_TW     = fomm_pkg::W_TW;
    localparam int W_ROT    = fomm_pkg::W_ROT;
    localparam int W_WHEEL  = fomm_pkg::W_WHEEL;
    localparam int W_MAG    = fomm_pkg::W_MAG;

    // Reciprocals: floor(n/15) for n < 2**30 and floor(n/45) for n < 2**31.
    localparam logic [30:0] R15 = 31'd1145324613;
    localparam logic [30:0] R45 = 31'd1527099484;

    localparam logic [1:0] QUAD_I   = 2'd0;
    localparam logic [1:0] QUAD_II  = 2'd1;
    localparam logic [1:0] QUAD_III = 2'd2;

    // Stage valids and load enables.
    logic [NS-1:0] r_vld;
    logic [NS-1:0] w_ld;

    always_comb begin
        w_ld[NS-1] = !r_vld[NS-1] || i_rdy;
        for (int k = NS - 2; k >= 0; k--) begin
            w_ld[k] = !r_vld[k] || w_ld[k+1];
        end
    end

    assign o_rdy = w_ld[0];
    assign o_vld = r_vld[NS-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_ld[0]) begin
                r_vld[0] <= i_vld;
            end
            for (int k = 1; k < NS; k++) begin
                if (w_ld[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // Stage 1 inputs: throttle scale products and heading operands.
    logic signed [16:0]    w_f;
    logic signed [32:0]    w_px;
    logic signed [32:0]    w_py;
    logic signed [32:0]    w_pt;
    logic signed [25:0]    w_n;
    logic [N_W-1:0]        w_num;
    logic [23:0]           w_habs;
    logic [29:0]           w_hmag;

    assign w_f    = {i_cmd.throttle[15], i_cmd.throttle} - 17'sd24576;
    assign w_px   = $signed(i_cmd.stick_x) * w_f;
    assign w_py   = $signed(i_cmd.stick_y) * w_f;
    assign w_pt   = $signed(i_cmd.stick_twist) * w_f;
    // Offset by a whole number of turns so the negated heading is positive.
    assign w_n    = 26'sd8409600 - {{2{i_cmd.heading[23]}}, i_cmd.heading};
    assign w_num  = {w_n[24:0], {TRIG_TABLE_BITS{1'b0}}} + N_W'(11520);
    assign w_habs = i_cmd.heading[23] ? (~i_cmd.heading + 24'd1) : i_cmd.heading;
    assign w_hmag = {w_habs, 6'd0} + 30'd7;

    logic                  r1_mode;
    logic signed [32:0]    r1_px;
    logic signed [32:0]    r1_py;
    logic signed [32:0]    r1_pt;
    logic [M_W-1:0]        r1_m;
    logic [29:0]           r1_hmag;
    logic                  r1_hneg;

    // Stage 2 inputs: rounding, deadband, autonomous twist, angle index.
    logic signed [39:0]      w_rx;
    logic signed [39:0]      w_ry;
    logic signed [39:0]      w_rt;
    logic [60:0]             w_tprod;
    logic [W_TW-1:0]         w_tq;
    logic signed [W_TW-1:0]  w_tw_auto;
    logic [M_W+30:0]         w_iprod;
    logic signed [W_S-1:0]   n2_sx;
    logic signed [W_S-1:0]   n2_sy;
    logic signed [W_TW-1:0]  n2_tw;

    assign w_rx      = fomm_pkg::dead_zone(fomm_pkg::mulq_round(40'(r1_px)), i_in_db);
    assign w_ry      = fomm_pkg::dead_zone(-fomm_pkg::mulq_round(40'(r1_py)), i_in_db);
    assign w_rt      = fomm_pkg::dead_zone(fomm_pkg::mulq_round(40'(r1_pt)), i_in_db);
    assign w_tprod   = r1_hmag * R15;
    assign w_tq      = w_tprod[60:34];
    assign w_tw_auto = r1_hneg ? -$signed(w_tq) : $signed(w_tq);
    assign w_iprod   = r1_m * R45;

    always_comb begin
        if (r1_mode) begin
            n2_sx = '0;
            n2_sy = W_S'(i_auton_fwd);
            n2_tw = w_tw_auto;
        end else begin
            n2_sx = w_rx[W_S-1:0];
            n2_sy = w_ry[W_S-1:0];
            n2_tw = W_TW'($signed(w_rt[W_S-1:0]));
        end
    end

    logic signed [W_S-1:0]       r2_sx;
    logic signed [W_S-1:0]       r2_sy;
    logic signed [W_TW-1:0]      r2_tw;
    logic [TRIG_TABLE_BITS-1:0]  r2_idx;

    // Quarter-wave sine and cosine tables, folded at elaboration.
    logic [14:0] w_sin_tab [QTR];
    logic [14:0] w_cos_tab [QTR];

    for (genvar g = 0; g < QTR; g++) begin : g_tab
        assign w_sin_tab[g] = fomm_pkg::quarter_sine(64'(g) << FR_SHIFT);
        assign w_cos_tab[g] = fomm_pkg::quarter_sine(fomm_pkg::Q30_ONE
                                                     - (64'(g) << FR_SHIFT));
    end

    // Stage 3 inputs: table read and quadrant symmetry.
    logic signed [15:0] w_sa;
    logic signed [15:0] w_sb;
    logic signed [15:0] n3_s;
    logic signed [15:0] n3_c;

    assign w_sa = {1'b0, w_sin_tab[r2_idx[QTR_BITS-1:0]]};
    assign w_sb = {1'b0, w_cos_tab[r2_idx[QTR_BITS-1:0]]};

    always_comb begin
        case (r2_idx[TRIG_TABLE_BITS-1 -: 2])
            QUAD_I: begin
                n3_s = w_sa;
                n3_c = w_sb;
            end
            QUAD_II: begin
                n3_s = w_sb;
                n3_c = -w_sa;
            end
            QUAD_III: begin
                n3_s = -w_sa;
                n3_c = -w_sb;
            end
            default: begin
                n3_s = -w_sb;
                n3_c = w_sa;
            end
        endcase
    end

    logic signed [W_S-1:0]  r3_sx;
    logic signed [W_S-1:0]  r3_sy;
    logic signed [W_TW-1:0] r3_tw;
    logic signed [15:0]     r3_s;
    logic signed [15:0]     r3_c;

    // Stage 4: rotation products.
    logic signed [33:0]     r4_sys;
    logic signed [33:0]     r4_sxc;
    logic signed [33:0]     r4_syc;
    logic signed [33:0]     r4_sxs;
    logic signed [W_TW-1:0] r4_tw;

    // Stage 5 inputs: rounded rotation.
    logic signed [39:0] w_rotx;
    logic signed [39:0] w_roty;

    assign w_rotx = fomm_pkg::mulq_round(40'(r4_sys)) - fomm_pkg::mulq_round(40'(r4_sxc));
    assign w_roty = fomm_pkg::mulq_round(40'(r4_syc)) - fomm_pkg::mulq_round(40'(r4_sxs));

    logic signed [W_ROT-1:0] r5_rx;
    logic signed [W_ROT-1:0] r5_ry;
    logic signed [W_TW-1:0]  r5_tw;

    // Stage 6 inputs: wheel mix with the forward axis negated.
    logic signed [W_WHEEL-1:0] w_ex;
    logic signed [W_WHEEL-1:0] w_ey;
    logic signed [W_WHEEL-1:0] w_et;
    logic signed [W_WHEEL-1:0] n6_w [4];

    assign w_ex = W_WHEEL'(r5_rx);
    assign w_ey = W_WHEEL'(r5_ry);
    assign w_et = W_WHEEL'(r5_tw);

    always_comb begin
        n6_w[0] = w_ex - w_ey + w_et;
        n6_w[1] = -w_ex - w_ey - w_et;
        n6_w[2] = -w_ex - w_ey + w_et;
        n6_w[3] = w_ex - w_ey - w_et;
    end

    logic signed [W_WHEEL-1:0] r6_w [4];

    // Stage 7 inputs: sign and magnitude per wheel.
    logic [W_WHEEL-1:0] w_abs [4];

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            w_abs[k] = r6_w[k][W_WHEEL-1] ? (~r6_w[k] + W_WHEEL'(1)) : r6_w[k];
        end
    end

    logic [W_MAG-1:0] r7_mag [4];
    logic [3:0]       r7_neg;

    // Stage 8 inputs: largest magnitude and divider set-up.
    logic [W_MAG-1:0]   w_m01;
    logic [W_MAG-1:0]   w_m23;
    logic [W_MAG-1:0]   w_max;
    fomm_pkg::t_div_bus n8_bus;

    assign w_m01 = (r7_mag[1] > r7_mag[0]) ? r7_mag[1] : r7_mag[0];
    assign w_m23 = (r7_mag[3] > r7_mag[2]) ? r7_mag[3] : r7_mag[2];
    assign w_max = (w_m23 > w_m01) ? w_m23 : w_m01;

    always_comb begin
        n8_bus.flag = w_max > W_MAG'(fomm_pkg::Q14_ONE);
        n8_bus.neg  = r7_neg;
        n8_bus.div  = {w_max, 1'b0};
        for (int k = 0; k < 4; k++) begin
            n8_bus.mag[k] = r7_mag[k];
            n8_bus.rem[k] = {1'b0, r7_mag[k], 15'd0} + fomm_pkg::W_REM'(w_max);
            n8_bus.quo[k] = '0;
        end
    end

    fomm_pkg::t_div_bus r8_bus;

    // Pipeline data registers.
    always_ff @(posedge i_clk) begin
        if (w_ld[0]) begin
            r1_mode <= i_cmd.mode;
            r1_px   <= w_px;
            r1_py   <= w_py;
            r1_pt   <= w_pt;
            r1_m    <= w_num[N_W-1:9];
            r1_hmag <= w_hmag;
            r1_hneg <= i_cmd.heading[23];
        end
        if (w_ld[1]) begin
            r2_sx  <= n2_sx;
            r2_sy  <= n2_sy;
            r2_tw  <= n2_tw;
            r2_idx <= w_iprod[36 +: TRIG_TABLE_BITS];
        end
        if (w_ld[2]) begin
            r3_sx <= r2_sx;
            r3_sy <= r2_sy;
            r3_tw <= r2_tw;
            r3_s  <= n3_s;
            r3_c  <= n3_c;
        end
        if (w_ld[3]) begin
            r4_sys <= r3_sy * r3_s;
            r4_sxc <= r3_sx * r3_c;
            r4_syc <= r3_sy * r3_c;
            r4_sxs <= r3_sx * r3_s;
            r4_tw  <= r3_tw;
        end
        if (w_ld[4]) begin
            r5_rx <= w_rotx[W_ROT-1:0];
            r5_ry <= w_roty[W_ROT-1:0];
            r5_tw <= r4_tw;
        end
        if (w_ld[5]) begin
            for (int k = 0; k < 4; k++) begin
                r6_w[k] <= n6_w[k];
            end
        end
        if (w_ld[6]) begin
            for (int k = 0; k < 4; k++) begin
                r7_mag[k] <= w_abs[k][W_MAG-1:0];
                r7_neg[k] <= r6_w[k][W_WHEEL-1];
            end
        end
        if (w_ld[7]) begin
            r8_bus <= n8_bus;
        end
    end

    assign o_bus = r8_bus;

endmodule

[hw/rtl/fomm_div_cell.sv]
// ----------------------------------------------------------------------------
// fomm_div_cell
// One restoring-division cell: settles one quotient bit for all four wheels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fomm_div_cell #(
    parameter int BIT = 0
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  fomm_pkg::t_div_bus i_bus,
    input  logic               i_vld,
    output logic               o_rdy,
    output fomm_pkg::t_div_bus o_bus,
    output logic               o_vld,
    input  logic               i_rdy
);

    logic                          r_vld;
    logic                          w_ld;
    logic [fomm_pkg::W_REM-1:0]    w_trial;
    fomm_pkg::t_div_bus            n_bus;
    fomm_pkg::t_div_bus            r_bus;

    assign w_ld    = !r_vld || i_rdy;
    assign o_rdy   = w_ld;
    assign o_vld   = r_vld;
    assign o_bus   = r_bus;
    assign w_trial = fomm_pkg::W_REM'(i_bus.div) << BIT;

    // Trial subtraction of the shifted denominator in every lane.
    always_comb begin
        n_bus = i_bus;
        for (int k = 0; k < 4; k++) begin
            if (i_bus.rem[k] >= w_trial) begin
                n_bus.rem[k]      = i_bus.rem[k] - w_trial;
                n_bus.quo[k][BIT] = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (w_ld) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ld) begin
            r_bus <= n_bus;
        end
    end

endmodule

[hw/rtl/field_oriented_mecanum_mixer.sv]
// ----------------------------------------------------------------------------
// Channel   Signals                                    Moves
// command   i_in_valid / o_in_ready / i_in_data        sticks, throttle, heading
// speeds    o_out_valid / i_out_ready / o_out_data     four wheel commands
// config    psel penable pwrite paddr pwdata prdata    deadbands, auton forward
//
// One transaction per cycle while the output is not stalled; 8 front stages, 15
// divider cells and one output register, the divider chain settling one bit per cell.
// Reset clears all stage valids and loads the register defaults; no sweep.
// A stalled output holds; empty stages upstream keep filling meanwhile.
// ----------------------------------------------------------------------------
// field_oriented_mecanum_mixer
// Field-oriented mecanum drive mixer with equalizing and deadbands.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module field_oriented_mecanum_mixer #(
    parameter int TRIG_TABLE_BITS = fomm_pkg::TRIG_TABLE_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  fomm_pkg::t_cmd                 i_in_data,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output fomm_pkg::t_speeds              o_out_data,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [fomm_pkg::APB_AW-1:0]    paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);

    localparam int NC = fomm_pkg::W_QUO;

    // Configuration registers.
    logic [14:0]        r_in_db;
    logic [14:0]        r_out_db;
    logic signed [15:0] r_auton_fwd;
    logic [1:0]         w_reg_idx;

    assign pready    = 1'b1;
    assign w_reg_idx = paddr[fomm_pkg::APB_AW-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_db     <= fomm_pkg::IN_DB_RST;
            r_out_db    <= fomm_pkg::OUT_DB_RST;
            r_auton_fwd <= fomm_pkg::AUTON_FWD_RST;
        end else if (psel && penable && pwrite) begin
            case (w_reg_idx)
                fomm_pkg::REG_IN_DB:     r_in_db     <= pwdata[14:0];
                fomm_pkg::REG_OUT_DB:    r_out_db    <= pwdata[14:0];
                fomm_pkg::REG_AUTON_FWD: r_auton_fwd <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // Register read-back.
    always_comb begin
        case (w_reg_idx)
            fomm_pkg::REG_IN_DB:     prdata = {17'd0, r_in_db};
            fomm_pkg::REG_OUT_DB:    prdata = {17'd0, r_out_db};
            fomm_pkg::REG_AUTON_FWD: prdata = {{16{r_auton_fwd[15]}}, r_auton_fwd};
            default:                 prdata = '0;
        endcase
    end

    // Front pipeline and divider chain.
    fomm_pkg::t_div_bus w_bus [NC+1];
    logic               w_vld [NC+1];
    logic               w_rdy [NC+1];

    fomm_front #(
        .TRIG_TABLE_BITS(TRIG_TABLE_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (i_in_data),
        .i_vld       (i_in_valid),
        .o_rdy       (o_in_ready),
        .i_in_db     (r_in_db),
        .i_auton_fwd (r_auton_fwd),
        .o_bus       (w_bus[0]),
        .o_vld       (w_vld[0]),
        .i_rdy       (w_rdy[0])
    );

    for (genvar g = 0; g < NC; g++) begin : g_cell
        fomm_div_cell #(
            .BIT(NC - 1 - g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_bus   (w_bus[g]),
            .i_vld   (w_vld[g]),
            .o_rdy   (w_rdy[g]),
            .o_bus   (w_bus[g+1]),
            .o_vld   (w_vld[g+1]),
            .i_rdy   (w_rdy[g+1])
        );
    end

    // Output stage: pick scaled or raw value, deadband, clamp, flip left side.
    logic                      r_out_vld;
    logic                      w_ld_out;
    fomm_pkg::t_speeds         r_out;
    fomm_pkg::t_div_bus        w_last;
    logic signed [39:0]        w_val [4];
    logic signed [15:0]        w_fin [4];
    fomm_pkg::t_speeds         n_out;

    assign w_last    = w_bus[NC];
    assign w_ld_out  = !r_out_vld || i_out_ready;
    assign w_rdy[NC] = w_ld_out;

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            if (w_last.flag) begin
                w_val[k] = w_last.neg[k] ? -$signed(40'(w_last.quo[k]))
                                         : $signed(40'(w_last.quo[k]));
            end else begin
                w_val[k] = w_last.neg[k] ? -$signed(40'(w_last.mag[k]))
                                         : $signed(40'(w_last.mag[k]));
            end
            w_fin[k] = fomm_pkg::sat_q14(fomm_pkg::dead_zone(w_val[k], r_out_db));
        end
        n_out.front_left_speed  = -w_fin[0];
        n_out.front_right_speed = w_fin[1];
        n_out.back_left_speed   = -w_fin[2];
        n_out.back_right_speed  = w_fin[3];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_ld_out) begin
            r_out_vld <= w_vld[NC];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ld_out) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

endmodule

[hw/rtl/fomm_checker.sv]
// ----------------------------------------------------------------------------
// fomm_checker
// Port-level checks for the mecanum mixer, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "field_oriented_mecanum_mixer_defines.svh"

module fomm_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              o_in_ready,
    input logic              o_out_valid,
    input logic              i_out_ready,
    input fomm_pkg::t_speeds o_out_data
);

    logic w_range_ok;

    // Every wheel command stays within -1.0 .. +1.0.
    assign w_range_ok =
        ($signed(o_out_data.front_left_speed)  >= -16'sd16384) &&
        ($signed(o_out_data.front_left_speed)  <=  16'sd16384) &&
        ($signed(o_out_data.front_right_speed) >= -16'sd16384) &&
        ($signed(o_out_data.front_right_speed) <=  16'sd16384) &&
        ($signed(o_out_data.back_left_speed)   >= -16'sd16384) &&
        ($signed(o_out_data.back_left_speed)   <=  16'sd16384) &&
        ($signed(o_out_data.back_right_speed)  >= -16'sd16384) &&
        ($signed(o_out_data.back_right_speed)  <=  16'sd16384);

    `FOMM_ASSERT_ALWAYS(a_reset_empties, i_clk, !i_rst_n |=> !o_out_valid, "output valid after reset")
    `FOMM_ASSERT(a_ready_when_drained, i_clk, i_rst_n, (!o_out_valid || i_out_ready) |-> o_in_ready, "input stalled with free output")
    `FOMM_ASSERT(a_speed_range, i_clk, i_rst_n, o_out_valid |-> w_range_ok, "wheel speed out of range")
    `FOMM_ASSERT(a_out_hold, i_clk, i_rst_n, (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out_data)), "stalled transaction changed")

endmodule

bind field_oriented_mecanum_mixer fomm_checker u_fomm_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);

[tb/mixer_checker.sv]
// ----------------------------------------------------------------------------
// Mecanum mixer checker
// Watches the command and speed channels, predicts the four wheel speeds of
// every accepted command and compares them with what the mixer returns.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mixer_checker (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_ready,
    input  fomm_pkg::t_cmd    i_in_data,
    input  logic              i_out_valid,
    input  logic              i_out_ready,
    input  fomm_pkg::t_speeds i_out_data,
    input  logic [14:0]       i_in_db,
    input  logic [14:0]       i_out_db,
    input  logic signed [15:0] i_auton_fwd,
    output int                o_fail_count,
    output int                o_pending,
    output int                o_cmd_count,
    output int                o_speed_count
);
    import fomm_pkg::*;

    localparam int TABLE_BITS = 10;
    localparam longint TURN = 23040;

    t_speeds wheel_queue[$];

    // Round n/d to nearest, ties away from zero (d positive).
    function automatic longint round_div(longint n, longint d);
        longint mag;
        mag = (n < 0) ? -n : n;
        mag = (mag + d / 2) / d;
        return (n < 0) ? -mag : mag;
    endfunction

    function automatic longint qmul(longint a, longint b);
        return round_div(a * b, 16384);
    endfunction

    function automatic longint mag_of(longint v);
        return (v < 0) ? -v : v;
    endfunction

    // Quarter-wave sine polynomial in Q30, result in Q1.14.
    function automatic longint quarter_wave(logic [63:0] x);
        logic [63:0] x2;
        logic [63:0] p;
        x2 = (x * x) >> 30;
        p = 64'd5026994 - ((x2 * 64'd172272) >> 30);
        p = 64'd85569305 - ((x2 * p) >> 30);
        p = 64'd693598668 - ((x2 * p) >> 30);
        p = 64'd1686629713 - ((x2 * p) >> 30);
        p = (x * p) >> 30;
        p = (p + 64'd32768) >> 16;
        if (p > 64'd16384) begin
            p = 64'd16384;
        end
        return longint'(p);
    endfunction

    // Expected speeds of one command under the current register values.
    function automatic t_speeds mix_wheels(t_cmd cmd);
        longint hd, sx, sy, tw, f, sn, cs, rx, ry, a, sa, sb, m;
        longint w[4];
        logic [63:0] idx, x;
        int quad;
        t_speeds r;
        hd = longint'(cmd.heading);
        if (cmd.mode) begin
            sx = 0;
            sy = longint'(i_auton_fwd);
            tw = round_div(hd * 64, 15);
        end else begin
            f = longint'(cmd.throttle) - 24576;
            sx = qmul(longint'(cmd.stick_x), f);
            sy = -qmul(longint'(cmd.stick_y), f);
            tw = qmul(longint'(cmd.stick_twist), f);
            if (mag_of(sx) < i_in_db) sx = 0;
            if (mag_of(sy) < i_in_db) sy = 0;
            if (mag_of(tw) < i_in_db) tw = 0;
        end
        // Angle lookup: negated heading wrapped to one turn.
        a = (-hd) % TURN;
        if (a < 0) a += TURN;
        idx = (a * (1 << TABLE_BITS) + TURN / 2) / TURN;
        idx &= (1 << TABLE_BITS) - 1;
        quad = int'(idx >> (TABLE_BITS - 2));
        x = (idx & ((1 << (TABLE_BITS - 2)) - 1)) << (32 - TABLE_BITS);
        sa = quarter_wave(x);
        sb = quarter_wave(64'd1073741824 - x);
        case (quad)
            0: begin sn = sa; cs = sb; end
            1: begin sn = sb; cs = -sa; end
            2: begin sn = -sa; cs = -sb; end
            default: begin sn = -sb; cs = sa; end
        endcase
        rx = qmul(sy, sn) - qmul(sx, cs);
        ry = qmul(sy, cs) - qmul(sx, sn);
        w[0] = rx - ry + tw;
        w[1] = -rx - ry - tw;
        w[2] = -rx - ry + tw;
        w[3] = rx - ry - tw;
        m = 0;
        for (int k = 0; k < 4; k++) begin
            if (mag_of(w[k]) > m) m = mag_of(w[k]);
        end
        for (int k = 0; k < 4; k++) begin
            if (m > 16384) w[k] = round_div(w[k] * 16384, m);
            if (mag_of(w[k]) < i_out_db) w[k] = 0;
            if (w[k] > 16384) w[k] = 16384;
            if (w[k] < -16384) w[k] = -16384;
        end
        r.front_left_speed = 16'(-w[0]);
        r.front_right_speed = 16'(w[1]);
        r.back_left_speed = 16'(-w[2]);
        r.back_right_speed = 16'(w[3]);
        return r;
    endfunction

    assign o_pending = wheel_queue.size();

    // Predict on each command transaction, compare on each speed transaction.
    always @(posedge i_clk) begin
        t_speeds want;
        if (!i_rst_n) begin
            o_fail_count <= 0;
            o_cmd_count <= 0;
            o_speed_count <= 0;
        end else begin
            if (i_in_valid && i_in_ready) begin
                wheel_queue.push_back(mix_wheels(i_in_data));
                o_cmd_count <= o_cmd_count + 1;
            end
            if (i_out_valid && i_out_ready) begin
                o_speed_count <= o_speed_count + 1;
                if (wheel_queue.size() == 0) begin
                    $error("speed transaction with no command waiting");
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = wheel_queue.pop_front();
                    if (want != i_out_data) begin
                        o_fail_count <= o_fail_count + 1;
                    end
                    if (want.front_left_speed != i_out_data.front_left_speed)
                        $error("front_left_speed expected %0d got %0d",
                               want.front_left_speed, i_out_data.front_left_speed);
                    if (want.front_right_speed != i_out_data.front_right_speed)
                        $error("front_right_speed expected %0d got %0d",
                               want.front_right_speed, i_out_data.front_right_speed);
                    if (want.back_left_speed != i_out_data.back_left_speed)
                        $error("back_left_speed expected %0d got %0d",
                               want.back_left_speed, i_out_data.back_left_speed);
                    if (want.back_right_speed != i_out_data.back_right_speed)
                        $error("back_right_speed expected %0d got %0d",
                               want.back_right_speed, i_out_data.back_right_speed);
                end
            end
        end
    end

endmodule

[tb/testbench.sv]
// ----------------------------------------------------------------------------
// Mecanum mixer testbench
// Drives commands and register writes into the mixer with random idle gaps
// on both channels; a checker beside the mixer predicts and compares.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
    import fomm_pkg::*;

    localparam int LATENCY = 24;
    localparam int WATCHDOG_LIMIT = 20000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_ready;
    t_cmd i_in_data = '0;
    logic o_out_valid;
    logic i_out_ready = 1'b0;
    t_speeds o_out_data;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [APB_AW-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    // Shadow copy of the registers for the checker.
    logic [14:0] in_db = IN_DB_RST;
    logic [14:0] out_db = OUT_DB_RST;
    logic signed [15:0] auton_fwd = AUTON_FWD_RST;

    int fail_count, pending, cmd_count, speed_count;
    int idle_cycles = 0;
    logic drain_mode = 1'b0;

    always #10 i_clk = ~i_clk;

    field_oriented_mecanum_mixer u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready), .i_in_data(i_in_data),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready), .o_out_data(o_out_data),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    mixer_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .i_in_ready(o_in_ready), .i_in_data(i_in_data),
        .i_out_valid(o_out_valid), .i_out_ready(i_out_ready), .i_out_data(o_out_data),
        .i_in_db(in_db), .i_out_db(out_db), .i_auton_fwd(auton_fwd),
        .o_fail_count(fail_count), .o_pending(pending),
        .o_cmd_count(cmd_count), .o_speed_count(speed_count)
    );

    function automatic int gap_len();
        if ($urandom_range(0, 99) < 3) return $urandom_range(10, 40);
        if ($urandom_range(0, 99) < 50) return 0;
        return $urandom_range(1, 3);
    endfunction

    // Random receiver stalls; a quiet stretch in drain mode.
    always @(negedge i_clk) begin
        if (drain_mode || $urandom_range(0, 9) < 7) begin
            i_out_ready <= 1'b1;
        end else begin
            i_out_ready <= 1'b0;
        end
    end

    // Watchdog on cycles with no transaction.
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // Valid stays high when the next transaction follows without a gap; the
    // caller drops it before anything other than another command.
    task automatic send_cmd(input t_cmd cmd);
        int g;
        g = gap_len();
        if (g > 0) begin
            i_in_valid <= 1'b0;
            repeat (g) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= cmd;
        do @(posedge i_clk); while (!o_in_ready);
        @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        @(negedge i_clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= APB_AW'(idx) << 2;
        pwdata <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_IN_DB: in_db = value[14:0];
            REG_OUT_DB: out_db = value[14:0];
            default: auton_fwd = value[15:0];
        endcase
    endtask

    // Wait until every prediction has been matched, then let the pipe settle.
    task automatic drain();
        i_in_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (LATENCY + 4) @(negedge i_clk);
    endtask

    function automatic logic signed [15:0] axis_val();
        case ($urandom_range(0, 5))
            0: return 16'sd16384;
            1: return -16'sd16384;
            2: return $signed(16'($urandom));
            3: return $signed(16'($urandom_range(0, 4000))) - 16'sd2000;
            default: return $signed(16'($urandom_range(0, 32768))) - 16'sd16384;
        endcase
    endfunction

    function automatic t_cmd rand_cmd();
        t_cmd c;
        c.mode = ($urandom_range(0, 4) == 0);
        c.stick_x = axis_val();
        c.stick_y = axis_val();
        c.stick_twist = axis_val();
        c.throttle = axis_val();
        case ($urandom_range(0, 3))
            0: c.heading = $signed(24'($urandom));
            1: c.heading = $signed(24'($urandom_range(0, 46080))) - 24'sd23040;
            default: c.heading = $signed(24'($urandom_range(0, 1000))) - 24'sd500;
        endcase
        return c;
    endfunction

    initial begin
        t_cmd c;
        logic [31:0] db_in_set[4] = '{0, 2458, 16384, 32767};
        logic [31:0] db_out_set[4] = '{0, 3277, 16384, 32767};
        logic [31:0] fwd_set[4] = '{32'hFFFF_C000, 32'h0000_4000, 0, 32'h0000_8000};
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: extremes, both modes, wrap points of the heading.
        for (int k = 0; k < 20; k++) begin
            c = '0;
            c.mode = k[0];
            c.stick_x = (k % 3 == 0) ? 16'sd16384 : -16'sd16384;
            c.stick_y = (k % 4 < 2) ? -16'sd16384 : 16'sd16384;
            c.stick_twist = (k % 5 == 0) ? 16'sd0 : 16'sd16384;
            c.throttle = (k < 10) ? -16'sd16384 : ((k < 15) ? 16'sd16384 : 16'sh7FFF);
            case (k % 6)
                0: c.heading = 24'sh7FFFFF;
                1: c.heading = -24'sh800000;
                2: c.heading = 24'sd11520;
                3: c.heading = -24'sd23040;
                4: c.heading = 24'sd0;
                default: c.heading = 24'sd45;
            endcase
            if (k == 19) c.throttle = -16'sh8000;
            send_cmd(c);
        end

        // Random phases under several register settings.
        for (int ph = 0; ph < 6; ph++) begin
            drain();
            write_reg(REG_IN_DB, (ph < 4) ? db_in_set[ph] : $urandom_range(0, 4000));
            write_reg(REG_OUT_DB, (ph < 4) ? db_out_set[ph] : $urandom_range(0, 4000));
            write_reg(REG_AUTON_FWD, (ph < 4) ? fwd_set[ph] : $urandom);
            for (int n = 0; n < 215; n++) send_cmd(rand_cmd());
        end

        drain_mode = 1'b1;
        drain();
        $display("Run covered %0d commands and %0d speed results over six register settings.",
                 cmd_count, speed_count);
        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
